@@ sv/qau_pkg.sv @@
`timescale 1ns / 1ps

package qau_pkg;

    localparam int LANES = 4;
    localparam int TERMS = 4;
    localparam int DW    = 16;
    localparam int PW    = 2 * DW;

    localparam logic [2:0] MODE_MUL = 3'd0;
    localparam logic [2:0] MODE_ADD = 3'd1;
    localparam logic [2:0] MODE_SUB = 3'd2;
    localparam logic [2:0] MODE_NEG = 3'd3;
    localparam logic [2:0] MODE_DOT = 3'd4;
    localparam logic [2:0] MODE_MAT = 3'd5;

    localparam logic [1:0] LAST_ROW = 2'd3;

    localparam int QW = 0;
    localparam int QX = 1;
    localparam int QY = 2;
    localparam int QZ = 3;

    typedef logic signed [DW-1:0] word_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] p_w;
        logic signed [15:0] p_x;
        logic signed [15:0] p_y;
        logic signed [15:0] p_z;
        logic signed [15:0] q_w;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] res_0;
        logic signed [15:0] res_1;
        logic signed [15:0] res_2;
        logic signed [15:0] res_3;
        logic [1:0]         row_index;
        logic               last;
    } out_item_t;

    // operand pairs, one per product term of each lane
    typedef struct packed {
        logic [LANES-1:0][TERMS-1:0][DW-1:0] a;
        logic [LANES-1:0][TERMS-1:0][DW-1:0] b;
    } ops_t;

    typedef struct packed {
        logic                            direct;
        logic                            dbl;
        logic [LANES-1:0]                bias;
        logic [LANES-1:0][TERMS-1:0]     neg;
        logic [LANES-1:0][DW-1:0]        dres;
        logic [1:0]                      row;
        logic                            last;
    } ctl_t;

    function automatic word_t sat17(input logic signed [DW:0] v);
        word_t r;
        if (v > 17'sd32767)
            r = 16'sh7FFF;
        else if (v < -17'sd32768)
            r = 16'sh8000;
        else
            r = v[DW-1:0];
        return r;
    endfunction

endpackage

@@ sv/qau_mac.sv @@
`timescale 1ns / 1ps

module qau_mac
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      ready,
    input  ops_t      ops,
    input  ctl_t      ctl,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res
);

    localparam int SUM_W = (2 * FRAC_BITS + 3 > 36) ? 2 * FRAC_BITS + 3 : 36;
    localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(64'sd1 <<< (2 * FRAC_BITS));
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] MINV = SUM_W'(-32768);

    logic en2, en3, en4;
    logic v2_reg, v3_reg, v4_reg;

    logic signed [PW-1:0]    prod_next [LANES][TERMS];
    logic signed [PW-1:0]    prod_reg  [LANES][TERMS];
    ctl_t                    ctl2_reg, ctl3_reg;
    logic signed [SUM_W-1:0] sum_next [LANES];
    logic signed [SUM_W-1:0] sum_reg  [LANES];
    out_item_t               res_next, res_reg;
    word_t                   lane_res [LANES];

    function automatic word_t round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] sh;
        word_t r;
        sh = (v + HALF) >>> FRAC_BITS;
        if (sh > MAXV)
            r = 16'sh7FFF;
        else if (sh < MINV)
            r = 16'sh8000;
        else
            r = sh[DW-1:0];
        return r;
    endfunction

    assign en4   = !v4_reg || !res_stall;
    assign en3   = !v3_reg || en4;
    assign en2   = !v2_reg || en3;
    assign ready = en2;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            for (int t = 0; t < TERMS; t++)
            begin
                prod_next[l][t] = $signed(ops.a[l][t]) * $signed(ops.b[l][t]);
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] term;
        for (int l = 0; l < LANES; l++)
        begin
            acc = '0;
            for (int t = 0; t < TERMS; t++)
            begin
                term = SUM_W'(prod_reg[l][t]);
                acc  = ctl2_reg.neg[l][t] ? acc - term : acc + term;
            end
            sum_next[l] = (ctl2_reg.dbl ? acc <<< 1 : acc)
                        + (ctl2_reg.bias[l] ? BIAS : SUM_W'(0));
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_res[l] = ctl3_reg.direct ? word_t'(ctl3_reg.dres[l]) : round_sat(sum_reg[l]);
        end
        res_next.res_0     = lane_res[0];
        res_next.res_1     = lane_res[1];
        res_next.res_2     = lane_res[2];
        res_next.res_3     = lane_res[3];
        res_next.row_index = ctl3_reg.row;
        res_next.last      = ctl3_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en2)
                v2_reg <= in_valid;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod_reg <= prod_next;
            ctl2_reg <= ctl;
        end
        if (en3)
        begin
            sum_reg  <= sum_next;
            ctl3_reg <= ctl2_reg;
        end
        if (en4)
            res_reg <= res_next;
    end

    assign res_valid = v4_reg;
    assign res       = res_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && res_stall |=> v4_reg && $stable(res_reg))
        else $error("result changed while stalled");

    a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && res_reg.row_index != 2'd0 && res_reg.row_index != LAST_ROW
            |-> !res_reg.last)
        else $error("last flag on an inner matrix row");

    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en3 |=> v2_reg && $stable(ctl2_reg))
        else $error("product stage lost an item");

endmodule

@@ sv/quaternion_arith_unit.sv @@
`timescale 1ns / 1ps

// Quaternion arithmetic in signed fixed point (FRAC_BITS fraction bits, Q3.12 by
// default): Hamilton product, sum, difference, negation, 4-D dot product and
// conversion to a 4x4 rotation matrix, all results saturated to 16 bits. An item
// enters every cycle unless the output stalls; matrix mode holds the input while
// its rows issue one per cycle from the input register, again unless the output
// stalls, so the input register's row sequencing sets the rate. Each result
// passes five register stages (input, operand select, 16 multipliers, lane sums,
// round and saturate) before it appears. Items with mode 6 or 7 are taken and produce no result.
module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    input  in_item_t  op_item,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_item
);

    localparam logic signed [DW-1:0] ONE_Q =
        (FRAC_BITS >= 15) ? 16'sh7FFF : DW'(32'sd1 <<< FRAC_BITS);

    logic     s0_valid_reg;
    in_item_t s0_item_reg;
    logic [1:0] s0_row_reg;
    logic     s0_last_slot;
    logic     op_acc;

    logic     s1_valid_reg;
    logic     s1_en;
    ops_t     ops_next, ops_reg;
    ctl_t     ctl_next, ctl_reg;
    logic     mac_ready;

    word_t    p [TERMS];
    word_t    q [TERMS];

    assign s0_last_slot = (s0_item_reg.mode != MODE_MAT) || (s0_row_reg == LAST_ROW);
    assign s1_en        = !s1_valid_reg || mac_ready;
    assign op_stall     = s0_valid_reg && !(s1_en && s0_last_slot);
    assign op_acc       = op_valid && !op_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_row_reg   <= 2'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_acc)
            begin
                s0_valid_reg <= (op_item.mode <= MODE_MAT);
                s0_row_reg   <= 2'd0;
            end
            else if (s0_valid_reg && s1_en)
            begin
                if (s0_last_slot)
                    s0_valid_reg <= 1'b0;
                else
                    s0_row_reg <= s0_row_reg + 2'd1;
            end
            if (s1_en)
                s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_acc)
            s0_item_reg <= op_item;
        if (s1_en)
        begin
            ops_reg <= ops_next;
            ctl_reg <= ctl_next;
        end
    end

    always_comb
    begin
        p[QW] = s0_item_reg.p_w;
        p[QX] = s0_item_reg.p_x;
        p[QY] = s0_item_reg.p_y;
        p[QZ] = s0_item_reg.p_z;
        q[QW] = s0_item_reg.q_w;
        q[QX] = s0_item_reg.q_x;
        q[QY] = s0_item_reg.q_y;
        q[QZ] = s0_item_reg.q_z;
    end

    always_comb
    begin
        ops_next      = '0;
        ctl_next      = '0;
        ctl_next.row  = s0_row_reg;
        ctl_next.last = s0_last_slot;
        case (s0_item_reg.mode)
            MODE_MUL:
            begin
                for (int t = 0; t < TERMS; t++)
                begin
                    ops_next.a[0][t] = p[t];
                    ops_next.b[0][t] = q[t];
                end
                ctl_next.neg[0] = 4'b1110;
                ops_next.a[1] = {p[QZ], p[QY], p[QX], p[QW]};
                ops_next.b[1] = {q[QY], q[QZ], q[QW], q[QX]};
                ops_next.a[2] = {p[QX], p[QZ], p[QY], p[QW]};
                ops_next.b[2] = {q[QZ], q[QX], q[QW], q[QY]};
                ops_next.a[3] = {p[QY], p[QX], p[QZ], p[QW]};
                ops_next.b[3] = {q[QX], q[QY], q[QW], q[QZ]};
                ctl_next.neg[1] = 4'b1000;
                ctl_next.neg[2] = 4'b1000;
                ctl_next.neg[3] = 4'b1000;
            end
            MODE_ADD:
            begin
                ctl_next.direct = 1'b1;
                for (int l = 0; l < LANES; l++)
                    ctl_next.dres[l] = sat17(17'(p[l]) + 17'(q[l]));
            end
            MODE_SUB:
            begin
                ctl_next.direct = 1'b1;
                for (int l = 0; l < LANES; l++)
                    ctl_next.dres[l] = sat17(17'(p[l]) - 17'(q[l]));
            end
            MODE_NEG:
            begin
                ctl_next.direct = 1'b1;
                for (int l = 0; l < LANES; l++)
                    ctl_next.dres[l] = sat17(-17'(p[l]));
            end
            MODE_DOT:
            begin
                for (int t = 0; t < TERMS; t++)
                begin
                    ops_next.a[0][t] = p[t];
                    ops_next.b[0][t] = q[t];
                end
            end
            MODE_MAT:
            begin
                ctl_next.dbl = 1'b1;
                case (s0_row_reg)
                    2'd0:
                    begin
                        ctl_next.bias[0] = 1'b1;
                        ops_next.a[0][1:0] = {p[QZ], p[QY]};
                        ops_next.b[0][1:0] = {p[QZ], p[QY]};
                        ctl_next.neg[0]    = 4'b0011;
                        ops_next.a[1][1:0] = {p[QZ], p[QX]};
                        ops_next.b[1][1:0] = {p[QW], p[QY]};
                        ctl_next.neg[1]    = 4'b0010;
                        ops_next.a[2][1:0] = {p[QY], p[QX]};
                        ops_next.b[2][1:0] = {p[QW], p[QZ]};
                    end
                    2'd1:
                    begin
                        ops_next.a[0][1:0] = {p[QZ], p[QX]};
                        ops_next.b[0][1:0] = {p[QW], p[QY]};
                        ctl_next.bias[1] = 1'b1;
                        ops_next.a[1][1:0] = {p[QZ], p[QX]};
                        ops_next.b[1][1:0] = {p[QZ], p[QX]};
                        ctl_next.neg[1]    = 4'b0011;
                        ops_next.a[2][1:0] = {p[QX], p[QY]};
                        ops_next.b[2][1:0] = {p[QW], p[QZ]};
                        ctl_next.neg[2]    = 4'b0010;
                    end
                    2'd2:
                    begin
                        ops_next.a[0][1:0] = {p[QY], p[QX]};
                        ops_next.b[0][1:0] = {p[QW], p[QZ]};
                        ctl_next.neg[0]    = 4'b0010;
                        ops_next.a[1][1:0] = {p[QX], p[QY]};
                        ops_next.b[1][1:0] = {p[QW], p[QZ]};
                        ctl_next.bias[2] = 1'b1;
                        ops_next.a[2][1:0] = {p[QY], p[QX]};
                        ops_next.b[2][1:0] = {p[QY], p[QX]};
                        ctl_next.neg[2]    = 4'b0011;
                    end
                    default:
                    begin
                        ctl_next.direct  = 1'b1;
                        ctl_next.dbl     = 1'b0;
                        ctl_next.dres[3] = ONE_Q;
                    end
                endcase
            end
            default:
            begin
                ctl_next.direct = 1'b1;
            end
        endcase
    end

    qau_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .ready     (mac_ready),
        .ops       (ops_reg),
        .ctl       (ctl_reg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_item)
    );

    a_mat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && s0_item_reg.mode == MODE_MAT && s0_row_reg != LAST_ROW
            |-> op_stall)
        else $error("input taken before matrix rows issued");

    a_row_mode: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && s0_row_reg != 2'd0 |-> s0_item_reg.mode == MODE_MAT)
        else $error("row count moved outside matrix mode");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !mac_ready |=> s1_valid_reg && $stable(ctl_reg) && $stable(ops_reg))
        else $error("operand stage lost an item");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import qau_pkg::*;

    localparam int FRAC             = 12;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_PER_PHASE = 32;

    // modes with no result
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam word_t W_MAX  = 16'sh7FFF;
    localparam word_t W_MIN  = 16'sh8000;
    localparam word_t W_ONE  = 16'sh1000;
    localparam word_t W_ZERO = 16'sh0000;
    localparam word_t W_COS45 = 16'sd2896;

    class quat_scoreboard;
        out_item_t expected_q[$];
        int errors;

        function word_t clip(longint v);
            if (v > 32767)
                return W_MAX;
            if (v < -32768)
                return W_MIN;
            return word_t'(v[15:0]);
        endfunction

        // round half up to FRAC fraction bits, then saturate
        function word_t round_clip(longint v);
            longint r;
            r = (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            return clip(r);
        endfunction

        function void push_row(word_t r0, word_t r1, word_t r2, word_t r3,
                               logic [1:0] row, logic last);
            out_item_t o;
            o.res_0     = r0;
            o.res_1     = r1;
            o.res_2     = r2;
            o.res_3     = r3;
            o.row_index = row;
            o.last      = last;
            expected_q.push_back(o);
        endfunction

        function void note_op(in_item_t it);
            longint pw, px, py, pz, qw, qx, qy, qz;
            longint one, xy, xz, yz, xx, yy, zz, xw, yw, zw;
            pw = it.p_w;
            px = it.p_x;
            py = it.p_y;
            pz = it.p_z;
            qw = it.q_w;
            qx = it.q_x;
            qy = it.q_y;
            qz = it.q_z;
            one = longint'(1) <<< (2 * FRAC);
            xy = 2 * px * py;
            xz = 2 * px * pz;
            yz = 2 * py * pz;
            xx = 2 * px * px;
            yy = 2 * py * py;
            zz = 2 * pz * pz;
            xw = 2 * px * pw;
            yw = 2 * py * pw;
            zw = 2 * pz * pw;
            case (it.mode)
                MODE_MUL:
                    push_row(round_clip(pw * qw - px * qx - py * qy - pz * qz),
                             round_clip(pw * qx + px * qw + py * qz - pz * qy),
                             round_clip(pw * qy + py * qw + pz * qx - px * qz),
                             round_clip(pw * qz + pz * qw + px * qy - py * qx),
                             2'd0, 1'b1);
                MODE_ADD:
                    push_row(clip(pw + qw), clip(px + qx), clip(py + qy), clip(pz + qz),
                             2'd0, 1'b1);
                MODE_SUB:
                    push_row(clip(pw - qw), clip(px - qx), clip(py - qy), clip(pz - qz),
                             2'd0, 1'b1);
                MODE_NEG:
                    push_row(clip(-pw), clip(-px), clip(-py), clip(-pz), 2'd0, 1'b1);
                MODE_DOT:
                    push_row(round_clip(pw * qw + px * qx + py * qy + pz * qz),
                             W_ZERO, W_ZERO, W_ZERO, 2'd0, 1'b1);
                MODE_MAT:
                begin
                    push_row(round_clip(one - (yy + zz)), round_clip(xy - zw),
                             round_clip(xz + yw), W_ZERO, 2'd0, 1'b0);
                    push_row(round_clip(xy + zw), round_clip(one - (xx + zz)),
                             round_clip(yz - xw), W_ZERO, 2'd1, 1'b0);
                    push_row(round_clip(xz - yw), round_clip(yz + xw),
                             round_clip(one - (xx + yy)), W_ZERO, 2'd2, 1'b0);
                    push_row(W_ZERO, W_ZERO, W_ZERO, clip(longint'(1) <<< FRAC),
                             LAST_ROW, 1'b1);
                end
                default:
                    ;
            endcase
        endfunction

        function void cmp(string field, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t %s mismatch: expected %0d, got %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_res(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, got %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            cmp("res_0", want.res_0, got.res_0);
            cmp("res_1", want.res_1, got.res_1);
            cmp("res_2", want.res_2, got.res_2);
            cmp("res_3", want.res_3, got.res_3);
            cmp("row_index", want.row_index, got.row_index);
            cmp("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      op_valid;
    logic      op_stall;
    in_item_t  op_item;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_item;

    int send_idle_pct;
    int stall_pct;
    int idle_run = 0;
    int phase_idle[4]  = '{0, 65, 0, 32};
    int phase_stall[4] = '{0, 0, 65, 32};

    quat_scoreboard sb;

    quaternion_arith_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_res(res_item);
            if ((op_valid && !op_stall) || (res_valid && !res_stall))
                idle_run = 0;
            else
                idle_run = idle_run + 1;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    function automatic in_item_t mk(logic [2:0] mode, word_t pw, word_t px, word_t py,
                                    word_t pz, word_t qw, word_t qx, word_t qy,
                                    word_t qz);
        in_item_t it;
        it.mode = mode;
        it.p_w  = pw;
        it.p_x  = px;
        it.p_y  = py;
        it.p_z  = pz;
        it.q_w  = qw;
        it.q_x  = qx;
        it.q_y  = qy;
        it.q_z  = qz;
        return it;
    endfunction

    // extremes, near-unit values, and full-range noise
    function automatic word_t random_word();
        case ($urandom_range(9))
            0: return W_MAX;
            1: return W_MIN;
            2: return W_ZERO;
            3, 4, 5: return word_t'(int'($urandom_range(8192)) - 4096);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_op();
        in_item_t it;
        if ($urandom_range(99) < 6)
            it.mode = $urandom_range(1) ? MODE_RSVD7 : MODE_RSVD6;
        else
            it.mode = 3'($urandom_range(MODE_MAT, MODE_MUL));
        it.p_w = random_word();
        it.p_x = random_word();
        it.p_y = random_word();
        it.p_z = random_word();
        it.q_w = random_word();
        it.q_x = random_word();
        it.q_y = random_word();
        it.q_z = random_word();
        return it;
    endfunction

    task automatic send_op(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            op_valid <= 1'b0;
            @(posedge clk);
        end
        op_valid <= 1'b1;
        op_item  <= it;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
        sb.note_op(it);
    endtask

    task automatic run_directed();
        send_op(mk(MODE_MUL, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_op(mk(MODE_MUL, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        send_op(mk(MODE_MUL, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN));
        // half-way products round toward plus infinity
        send_op(mk(MODE_MUL, 16'sd1, W_ZERO, W_ZERO, W_ZERO,
                   16'sd2048, W_ZERO, W_ZERO, W_ZERO));
        send_op(mk(MODE_MUL, -16'sd1, W_ZERO, W_ZERO, W_ZERO,
                   16'sd2048, W_ZERO, W_ZERO, W_ZERO));
        send_op(mk(MODE_MUL, W_ONE, 16'sd1234, -16'sd567, 16'sd89,
                   W_COS45, W_COS45, W_ZERO, W_ZERO));
        send_op(mk(MODE_ADD, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_op(mk(MODE_ADD, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        send_op(mk(MODE_ADD, W_ONE, -16'sd1, W_ZERO, 16'sd7,
                   -16'sd4096, 16'sd1, W_MAX, W_MIN));
        send_op(mk(MODE_SUB, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN));
        send_op(mk(MODE_SUB, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX));
        // negating the most negative value saturates
        send_op(mk(MODE_NEG, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX));
        send_op(mk(MODE_NEG, W_MAX, W_ONE, -16'sd1, W_ZERO,
                   W_MIN, W_MIN, W_MIN, W_MIN));
        send_op(mk(MODE_DOT, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_op(mk(MODE_DOT, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN));
        send_op(mk(MODE_DOT, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
                   W_ZERO, W_ZERO, W_ZERO, W_ZERO));
        send_op(mk(MODE_MAT, W_ONE, W_ZERO, W_ZERO, W_ZERO,
                   W_ZERO, W_ZERO, W_ZERO, W_ZERO));
        send_op(mk(MODE_MAT, W_COS45, W_COS45, W_ZERO, W_ZERO,
                   W_ONE, W_ONE, W_ONE, W_ONE));
        send_op(mk(MODE_MAT, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_op(mk(MODE_MAT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        send_op(mk(MODE_RSVD6, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE));
        send_op(mk(MODE_RSVD7, W_MAX, W_MIN, W_ONE, W_ZERO,
                   W_MAX, W_MIN, W_ONE, W_ZERO));
    endtask

    task automatic run_random(input int count);
        int done;
        in_item_t it;
        done = 0;
        while (done < count)
        begin
            it = random_op();
            send_op(it);
            if (it.mode <= MODE_MAT)
                done++;
        end
    endtask

    initial
    begin
        sb = new;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n     <= 1'b0;
        op_valid  <= 1'b0;
        op_item   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = phase_idle[ph];
            stall_pct     = phase_stall[ph];
            run_random(RANDOM_PER_PHASE);
        end
        op_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
